### rtl/core/blld_pkg.sv
// Shared types, constants and register indexes for the beacon loss detector.
package blld_pkg;

   // Number of history bytes examined per poll, one lane per byte.
   localparam int HISTORY_LEN = 8;

   // Field widths of one poll word.
   localparam int ADDR_W   = 48;
   localparam int SIGNAL_W = 8;
   localparam int BYTES_W  = 32;
   localparam int TIME_W   = 63;
   localparam int HIST_W   = 8 * HISTORY_LEN;
   localparam int LEN_W    = 4;
   localparam int COUNT_W  = 8;
   localparam int WINDOW_W = 32;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_LOST_MARKER_PRIMARY   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOST_MARKER_SECONDARY = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_SCREEN_ON      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_SCREEN_OFF     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_POLLS_SCREEN_ON   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_POLLS_SCREEN_OFF  = 3'd5;

   // Register reset values.
   localparam logic signed [SIGNAL_W-1:0] LOST_MARKER_PRIMARY_RST   = -8'sd127;
   localparam logic signed [SIGNAL_W-1:0] LOST_MARKER_SECONDARY_RST = -8'sd128;
   localparam logic [WINDOW_W-1:0]        WINDOW_SCREEN_ON_RST      = 32'd12000;
   localparam logic [WINDOW_W-1:0]        WINDOW_SCREEN_OFF_RST     = 32'd3000;
   localparam logic [COUNT_W-1:0]         MIN_POLLS_SCREEN_ON_RST   = 8'd5;
   localparam logic [COUNT_W-1:0]         MIN_POLLS_SCREEN_OFF_RST  = 8'd3;

   // Saturation value of the qualifying poll count.
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // History length that a poll must reach to qualify.
   localparam logic [LEN_W-1:0] HISTORY_LEN_MIN = LEN_W'(HISTORY_LEN);

   // Configuration register set.
   typedef struct packed {
      logic signed [SIGNAL_W-1:0] lost_marker_primary;
      logic signed [SIGNAL_W-1:0] lost_marker_secondary;
      logic [WINDOW_W-1:0]        window_screen_on;
      logic [WINDOW_W-1:0]        window_screen_off;
      logic [COUNT_W-1:0]         min_polls_screen_on;
      logic [COUNT_W-1:0]         min_polls_screen_off;
   } blld_cfg_type;

   // Classification of one history byte.
   typedef struct packed {
      logic is_lost;     // byte is a primary marker, a secondary marker or zero
      logic is_primary;  // byte is the primary marker
   } blld_lane_flags_type;

endpackage

### rtl/core/blld_lane.sv
// One history lane: classifies a single raw beacon signal byte.
module blld_lane (
   input  logic [7:0]                   hist_byte,
   input  blld_pkg::blld_cfg_type       cfg,
   output blld_pkg::blld_lane_flags_type flags
);
   import blld_pkg::*;

   logic match_primary;
   logic match_secondary;

   // Compare the byte against both markers and zero.
   assign match_primary   = (hist_byte == cfg.lost_marker_primary);
   assign match_secondary = (hist_byte == cfg.lost_marker_secondary);

   assign flags.is_primary = match_primary;
   assign flags.is_lost    = match_primary || match_secondary || (hist_byte == 8'h00);

endmodule

### rtl/core/blld_merge.sv
// Merges the lane flags into a single history verdict.
module blld_merge (
   input  blld_pkg::blld_lane_flags_type [blld_pkg::HISTORY_LEN-1:0] lane_flags,
   output logic                                                     history_lost
);
   import blld_pkg::*;

   logic all_lost;
   logic any_primary;

   // Every lane must report a lost byte and at least one the primary marker.
   always_comb begin
      all_lost    = 1'b1;
      any_primary = 1'b0;
      for (int i = 0; i < HISTORY_LEN; i++) begin
         all_lost    = all_lost & lane_flags[i].is_lost;
         any_primary = any_primary | lane_flags[i].is_primary;
      end
   end

   assign history_lost = all_lost && any_primary;

endmodule

### rtl/core/blld_track.sv
// Link tracking state, qualifying window and count, and the loss decision.
module blld_track (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [blld_pkg::ADDR_W-1:0]    peer_address,
   input  logic signed [blld_pkg::SIGNAL_W-1:0] signal_level,
   input  logic [blld_pkg::BYTES_W-1:0]   received_bytes,
   input  logic                           screen_on,
   input  logic [blld_pkg::TIME_W-1:0]    poll_time,
   input  logic [blld_pkg::LEN_W-1:0]     history_length,
   input  logic                           history_lost,
   input  blld_pkg::blld_cfg_type         cfg,
   output logic                           beacon_lost
);
   import blld_pkg::*;

   logic                       tracking_valid_ff, tracking_valid_in;
   logic [ADDR_W-1:0]          tracked_address_ff, tracked_address_in;
   logic signed [SIGNAL_W-1:0] tracked_signal_ff, tracked_signal_in;
   logic [BYTES_W-1:0]         tracked_bytes_ff, tracked_bytes_in;
   logic                       tracked_screen_ff, tracked_screen_in;
   logic [TIME_W-1:0]          window_start_ff, window_start_in;
   logic [COUNT_W-1:0]         qualifying_ff, qualifying_in;

   logic                link_changed;
   logic                poll_qualifies;
   logic [COUNT_W-1:0]  count_inc;
   logic [TIME_W-1:0]   elapsed;
   logic [WINDOW_W-1:0] window_sel;
   logic [COUNT_W-1:0]  min_polls_sel;
   logic                window_met;

   // The link counts as unchanged only if all four tracked values match.
   assign link_changed = !tracking_valid_ff
                         || (tracked_address_ff != peer_address)
                         || (tracked_signal_ff != signal_level)
                         || (tracked_bytes_ff != received_bytes)
                         || (tracked_screen_ff != screen_on);

   assign poll_qualifies = (history_length >= HISTORY_LEN_MIN) && history_lost;

   // Saturating increment of the qualifying count.
   assign count_inc = (qualifying_ff == COUNT_MAX) ? COUNT_MAX : qualifying_ff + 1'b1;

   // Window and minimum count follow the screen flag.
   assign window_sel    = screen_on ? cfg.window_screen_on : cfg.window_screen_off;
   assign min_polls_sel = screen_on ? cfg.min_polls_screen_on : cfg.min_polls_screen_off;
   assign elapsed       = poll_time - window_start_ff;
   assign window_met    = (elapsed >= {{(TIME_W-WINDOW_W){1'b0}}, window_sel})
                          && (count_inc >= min_polls_sel);

   // Next-state and decision for the word being accepted.
   always_comb begin
      tracking_valid_in  = tracking_valid_ff;
      tracked_address_in = tracked_address_ff;
      tracked_signal_in  = tracked_signal_ff;
      tracked_bytes_in   = tracked_bytes_ff;
      tracked_screen_in  = tracked_screen_ff;
      window_start_in    = window_start_ff;
      qualifying_in      = qualifying_ff;
      beacon_lost        = 1'b0;
      if (link_changed) begin
         tracking_valid_in  = 1'b1;
         tracked_address_in = peer_address;
         tracked_signal_in  = signal_level;
         tracked_bytes_in   = received_bytes;
         tracked_screen_in  = screen_on;
         window_start_in    = '0;
         qualifying_in      = '0;
      end else if (!poll_qualifies) begin
         window_start_in = '0;
         qualifying_in   = '0;
      end else if (window_start_ff == '0) begin
         // A window opens at this poll.
         window_start_in = poll_time;
         qualifying_in   = count_inc;
      end else if (poll_time <= window_start_ff) begin
         // Time did not advance, so the window restarts here.
         window_start_in = poll_time;
         qualifying_in   = COUNT_W'(1);
      end else if (window_met) begin
         window_start_in = poll_time;
         qualifying_in   = COUNT_W'(1);
         beacon_lost     = 1'b1;
      end else begin
         qualifying_in = count_inc;
      end
   end

   // Tracking state updates only on an accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         tracking_valid_ff  <= 1'b0;
         tracked_address_ff <= '0;
         tracked_signal_ff  <= '0;
         tracked_bytes_ff   <= '0;
         tracked_screen_ff  <= 1'b0;
         window_start_ff    <= '0;
         qualifying_ff      <= '0;
      end else if (accept) begin
         tracking_valid_ff  <= tracking_valid_in;
         tracked_address_ff <= tracked_address_in;
         tracked_signal_ff  <= tracked_signal_in;
         tracked_bytes_ff   <= tracked_bytes_in;
         tracked_screen_ff  <= tracked_screen_in;
         window_start_ff    <= window_start_in;
         qualifying_ff      <= qualifying_in;
      end
   end

   // Nothing tracked means no window and no count.
   assert property (@(posedge clock) disable iff (reset)
      !tracking_valid_ff |-> (qualifying_ff == '0) && (window_start_ff == '0))
      else $error("count or window set while no link is tracked");

   // A changed link clears the window and the count.
   assert property (@(posedge clock) disable iff (reset)
      accept && link_changed |=> (qualifying_ff == '0) && (window_start_ff == '0))
      else $error("link change did not clear window state");

   // A report restarts the window at the reporting poll with a count of one.
   assert property (@(posedge clock) disable iff (reset)
      accept && beacon_lost |=> (qualifying_ff == COUNT_W'(1))
                                && (window_start_ff == $past(poll_time)))
      else $error("window not restarted after a loss report");

endmodule

### rtl/core/beacon_loss_detector_core.sv
// Top level of the beacon loss detector: lanes, merge, tracking and output stage.
//
// The detector takes one poll word per clock cycle while req_stall is low and
// delivers one result word per poll, in order, from its output register. Each
// history byte is classified by its own lane, the lane flags are merged, and
// the tracking logic updates the link state and decides beacon_lost in the same
// cycle as the accept; the sustained rate is one poll per cycle while unstalled.
// An output register backed by a one-word skid stage lets the block keep
// accepting polls while a result waits; req_stall rises only when both hold a
// word. Configuration writes take effect at the next edge.
module beacon_loss_detector_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // Poll channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [blld_pkg::ADDR_W-1:0]           req_peer_address,
   input  logic signed [blld_pkg::SIGNAL_W-1:0]  req_signal_level,
   input  logic [blld_pkg::BYTES_W-1:0]          req_received_bytes,
   input  logic                                  req_screen_on,
   input  logic [blld_pkg::TIME_W-1:0]           req_poll_time,
   input  logic [blld_pkg::HIST_W-1:0]           req_history_bytes,
   input  logic [blld_pkg::LEN_W-1:0]            req_history_length,
   // Result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_beacon_lost,
   // Configuration port
   input  logic                                  csr_write_enable,
   input  logic [blld_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [blld_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import blld_pkg::*;

   blld_cfg_type cfg_ff, cfg_in;

   blld_lane_flags_type [HISTORY_LEN-1:0] lane_flags;
   logic history_lost;
   logic decision;
   logic accept;
   logic out_take;

   logic out_valid_ff, out_valid_in;
   logic out_lost_ff, out_lost_in;
   logic skid_valid_ff, skid_valid_in;
   logic skid_lost_ff, skid_lost_in;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_LOST_MARKER_PRIMARY:   cfg_in.lost_marker_primary   = csr_write_data[7:0];
            CSR_LOST_MARKER_SECONDARY: cfg_in.lost_marker_secondary = csr_write_data[7:0];
            CSR_WINDOW_SCREEN_ON:      cfg_in.window_screen_on      = csr_write_data;
            CSR_WINDOW_SCREEN_OFF:     cfg_in.window_screen_off     = csr_write_data;
            CSR_MIN_POLLS_SCREEN_ON:   cfg_in.min_polls_screen_on   = csr_write_data[7:0];
            CSR_MIN_POLLS_SCREEN_OFF:  cfg_in.min_polls_screen_off  = csr_write_data[7:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lost_marker_primary   <= LOST_MARKER_PRIMARY_RST;
         cfg_ff.lost_marker_secondary <= LOST_MARKER_SECONDARY_RST;
         cfg_ff.window_screen_on      <= WINDOW_SCREEN_ON_RST;
         cfg_ff.window_screen_off     <= WINDOW_SCREEN_OFF_RST;
         cfg_ff.min_polls_screen_on   <= MIN_POLLS_SCREEN_ON_RST;
         cfg_ff.min_polls_screen_off  <= MIN_POLLS_SCREEN_OFF_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // One classification lane per history byte.
   for (genvar g = 0; g < HISTORY_LEN; g++) begin : g_lane
      blld_lane u_lane (
         .hist_byte (req_history_bytes[8*g +: 8]),
         .cfg       (cfg_ff),
         .flags     (lane_flags[g])
      );
   end

   blld_merge u_merge (
      .lane_flags   (lane_flags),
      .history_lost (history_lost)
   );

   blld_track u_track (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .peer_address   (req_peer_address),
      .signal_level   (req_signal_level),
      .received_bytes (req_received_bytes),
      .screen_on      (req_screen_on),
      .poll_time      (req_poll_time),
      .history_length (req_history_length),
      .history_lost   (history_lost),
      .cfg            (cfg_ff),
      .beacon_lost    (decision)
   );

   // Handshake: input stalls only while the skid stage holds a word.
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_take  = out_valid_ff && !rsp_stall;

   // Output register with skid stage.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_lost_in   = out_lost_ff;
      skid_valid_in = skid_valid_ff;
      skid_lost_in  = skid_lost_ff;
      if (!out_valid_ff || out_take) begin
         out_valid_in  = skid_valid_ff || accept;
         out_lost_in   = skid_valid_ff ? skid_lost_ff : decision;
         skid_valid_in = 1'b0;
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_lost_in  = decision;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_lost_ff  <= out_lost_in;
      skid_lost_ff <= skid_lost_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_beacon_lost = out_lost_ff;

   // The skid stage is only ever filled behind a full output register.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held with empty output register");

   // A word accepted behind a stalled result lands in the skid stage.
   assert property (@(posedge clock) disable iff (reset)
      accept && out_valid_ff && rsp_stall |=> skid_valid_ff && out_valid_ff)
      else $error("accepted word lost behind a stalled result");

   // After an accept the output register always holds a result word.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> out_valid_ff)
      else $error("accepted word produced no result");

endmodule

### verif/beacon_loss_detector_core_test.sv
// Self-checking testbench for the beacon loss detector core: directed, saturation and random polls.
module beacon_loss_detector_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import blld_pkg::*;

   localparam int DRAIN_CYCLES = 4;
   localparam int RESULT_WAIT_LIMIT = 5000;

   // One poll word, field by field as the request ports carry it.
   typedef struct packed {
      logic [ADDR_W-1:0]          peer_address;
      logic signed [SIGNAL_W-1:0] signal_level;
      logic [BYTES_W-1:0]         received_bytes;
      logic                       screen_on;
      logic [TIME_W-1:0]          poll_time;
      logic [HIST_W-1:0]          history_bytes;
      logic [LEN_W-1:0]           history_length;
   } poll_word_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [ADDR_W-1:0]          req_peer_address = '0;
   logic signed [SIGNAL_W-1:0] req_signal_level = '0;
   logic [BYTES_W-1:0]         req_received_bytes = '0;
   logic                       req_screen_on = 1'b0;
   logic [TIME_W-1:0]          req_poll_time = '0;
   logic [HIST_W-1:0]          req_history_bytes = '0;
   logic [LEN_W-1:0]           req_history_length = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_beacon_lost;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_write_data = '0;

   // Mirror of the register set and of the tracked link.
   blld_cfg_type               cfg_shadow;
   bit                         link_valid;
   logic [ADDR_W-1:0]          link_address;
   logic signed [SIGNAL_W-1:0] link_signal;
   logic [BYTES_W-1:0]         link_bytes;
   logic                       link_screen;
   logic [63:0]                window_start;
   logic [COUNT_W-1:0]         polls_counted;

   bit                         pending_beacon_lost[$];
   bit                         expected_lost;
   int                         error_count = 0;
   int                         burst_left = 0;
   logic [10:0]                stall_cycle = '0;

   beacon_loss_detector_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_peer_address   (req_peer_address),
      .req_signal_level   (req_signal_level),
      .req_received_bytes (req_received_bytes),
      .req_screen_on      (req_screen_on),
      .req_poll_time      (req_poll_time),
      .req_history_bytes  (req_history_bytes),
      .req_history_length (req_history_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_beacon_lost    (rsp_beacon_lost),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver cycles through calm, light, heavy and periodic stall stretches.
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 11'd1;
      case (stall_cycle[10:9])
         2'd0: rsp_stall <= 1'b0;
         2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2'd2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ((stall_cycle % 11'd7) < 11'd3);
      endcase
   end

   // Each result word is compared with the oldest expected beacon_lost.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beacon_lost.size() == 0) begin
            $error("beacon_lost: result word with no poll outstanding (actual %0b)",
                   rsp_beacon_lost);
            error_count++;
         end else begin
            expected_lost = pending_beacon_lost.pop_front();
            if (rsp_beacon_lost !== expected_lost) begin
               $error("beacon_lost mismatch: expected %0b, actual %0b",
                      expected_lost, rsp_beacon_lost);
               error_count++;
            end
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // True when every history byte is a marker or zero and one is the primary marker.
   function automatic bit history_all_lost(input logic [HIST_W-1:0] h);
      bit         clean;
      bit         primary_seen;
      logic [7:0] b;
      clean = 1'b1;
      primary_seen = 1'b0;
      for (int i = 0; i < HISTORY_LEN; i++) begin
         b = h[8*i +: 8];
         if (b != cfg_shadow.lost_marker_primary && b != cfg_shadow.lost_marker_secondary &&
             b != 8'h00)
            clean = 1'b0;
         if (b == cfg_shadow.lost_marker_primary)
            primary_seen = 1'b1;
      end
      return clean && primary_seen;
   endfunction

   // Advances the link tracking by one poll and returns the expected beacon_lost.
   function automatic bit predict_beacon_lost(input poll_word_type p);
      logic [63:0]         t;
      logic [WINDOW_W-1:0] win;
      logic [COUNT_W-1:0]  need;
      t = {1'b0, p.poll_time};
      if (!link_valid || link_address != p.peer_address || link_signal != p.signal_level ||
          link_bytes != p.received_bytes || link_screen != p.screen_on) begin
         link_valid = 1'b1;
         link_address = p.peer_address;
         link_signal = p.signal_level;
         link_bytes = p.received_bytes;
         link_screen = p.screen_on;
         window_start = '0;
         polls_counted = '0;
         return 1'b0;
      end
      if (p.history_length < HISTORY_LEN_MIN || !history_all_lost(p.history_bytes)) begin
         window_start = '0;
         polls_counted = '0;
         return 1'b0;
      end
      if (polls_counted != COUNT_MAX)
         polls_counted = polls_counted + 1'b1;
      // A start time of zero still reads as a closed window.
      if (window_start == 64'd0) begin
         window_start = t;
         return 1'b0;
      end
      if (t <= window_start) begin
         window_start = t;
         polls_counted = 8'd1;
         return 1'b0;
      end
      win = p.screen_on ? cfg_shadow.window_screen_on : cfg_shadow.window_screen_off;
      need = p.screen_on ? cfg_shadow.min_polls_screen_on : cfg_shadow.min_polls_screen_off;
      if (t - window_start >= {32'd0, win} && polls_counted >= need) begin
         window_start = t;
         polls_counted = 8'd1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Sends one poll word, opening a new burst after a random gap when the last one ran out.
   task automatic send_poll(input poll_word_type p);
      int idle;
      bit lost_now;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 20);
         idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (idle > 0) begin
            req_valid <= 1'b0;
            repeat (idle) @(posedge clock);
         end
      end
      burst_left--;
      req_peer_address <= p.peer_address;
      req_signal_level <= p.signal_level;
      req_received_bytes <= p.received_bytes;
      req_screen_on <= p.screen_on;
      req_poll_time <= p.poll_time;
      req_history_bytes <= p.history_bytes;
      req_history_length <= p.history_length;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      lost_now = predict_beacon_lost(p);
      pending_beacon_lost.insert(pending_beacon_lost.size(), lost_now);
   endtask

   // Holds the sender back until every expected word has come and the block has settled.
   task automatic drain_results();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (pending_beacon_lost.size() != 0 && waited < RESULT_WAIT_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_beacon_lost.size() != 0) begin
         $error("beacon_lost: %0d expected result words never arrived",
                pending_beacon_lost.size());
         error_count++;
         pending_beacon_lost.delete();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   // Writes the whole register set; the block must be idle.
   task automatic write_config(input blld_cfg_type c);
      write_register(CSR_LOST_MARKER_PRIMARY, {24'd0, c.lost_marker_primary});
      write_register(CSR_LOST_MARKER_SECONDARY, {24'd0, c.lost_marker_secondary});
      write_register(CSR_WINDOW_SCREEN_ON, c.window_screen_on);
      write_register(CSR_WINDOW_SCREEN_OFF, c.window_screen_off);
      write_register(CSR_MIN_POLLS_SCREEN_ON, {24'd0, c.min_polls_screen_on});
      write_register(CSR_MIN_POLLS_SCREEN_OFF, {24'd0, c.min_polls_screen_off});
      csr_write_enable <= 1'b0;
      cfg_shadow = c;
      @(posedge clock);
   endtask

   function automatic logic [WINDOW_W-1:0] pick_window();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return WINDOW_W'($urandom_range(1, 5000));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [COUNT_W-1:0] pick_min_polls();
      case ($urandom_range(0, 3))
         0: return 8'd1;
         1: return COUNT_MAX;
         2: return 8'($urandom_range(1, 8));
         default: return 8'($urandom_range(2, 20));
      endcase
   endfunction

   function automatic blld_cfg_type pick_config();
      blld_cfg_type c;
      c.lost_marker_primary = 8'($urandom);
      c.lost_marker_secondary = 8'($urandom);
      case ($urandom_range(0, 3))
         0: c.lost_marker_secondary = c.lost_marker_primary;
         1: c.lost_marker_secondary = '0;
         2: begin
            c.lost_marker_primary = LOST_MARKER_PRIMARY_RST;
            c.lost_marker_secondary = LOST_MARKER_SECONDARY_RST;
         end
         default: ;
      endcase
      c.window_screen_on = pick_window();
      c.window_screen_off = pick_window();
      c.min_polls_screen_on = pick_min_polls();
      c.min_polls_screen_off = pick_min_polls();
      return c;
   endfunction

   // History of markers and zeros under the current markers, optionally holding a primary.
   function automatic logic [HIST_W-1:0] lost_history(input bit with_primary);
      logic [HIST_W-1:0] h;
      for (int i = 0; i < HISTORY_LEN; i++) begin
         case ($urandom_range(0, with_primary ? 2 : 1))
            0: h[8*i +: 8] = cfg_shadow.lost_marker_secondary;
            1: h[8*i +: 8] = 8'h00;
            default: h[8*i +: 8] = cfg_shadow.lost_marker_primary;
         endcase
      end
      if (with_primary)
         h[8*$urandom_range(0, HISTORY_LEN - 1) +: 8] = cfg_shadow.lost_marker_primary;
      return h;
   endfunction

   // Any length code may come in, including those above the history size.
   function automatic poll_word_type random_poll();
      poll_word_type p;
      p.peer_address = ADDR_W'(rand64());
      p.signal_level = 8'($urandom);
      p.received_bytes = $urandom;
      p.screen_on = 1'($urandom);
      p.poll_time = TIME_W'(rand64());
      p.history_bytes = rand64();
      p.history_length = 4'($urandom_range(0, 15));
      return p;
   endfunction

   // Runs episodes on one link each: mostly qualifying polls with time steps scaled to the
   // window, mixed with broken histories, stalled clocks, link changes and noise words.
   task automatic run_link_episodes(input int total);
      poll_word_type       link_poll;
      poll_word_type       p;
      logic [63:0]         clock_now;
      logic [63:0]         base;
      logic [63:0]         step;
      logic [WINDOW_W-1:0] win;
      logic [COUNT_W-1:0]  need;
      int                  left;
      int                  kind;
      int                  lane;
      left = total;
      while (left > 0) begin
         link_poll = random_poll();
         case ($urandom_range(0, 3))
            0: clock_now = '0;
            1: clock_now = 64'($urandom_range(1, 1000));
            2: clock_now = {32'd0, $urandom};
            default: clock_now = rand64() >> 1;
         endcase
         repeat ($urandom_range(3, 40)) begin
            if (left == 0)
               break;
            p = link_poll;
            kind = $urandom_range(0, 99);
            win = p.screen_on ? cfg_shadow.window_screen_on : cfg_shadow.window_screen_off;
            need = p.screen_on ? cfg_shadow.min_polls_screen_on
                               : cfg_shadow.min_polls_screen_off;
            base = {32'd0, win} / ((need == '0) ? 64'd1 : {56'd0, need}) + 64'd1;
            step = rand64() % (2 * base + 64'd1);
            p.history_bytes = lost_history(1'b1);
            p.history_length = HISTORY_LEN_MIN;
            if (kind < 70) begin
               clock_now = clock_now + step;
            end else if (kind < 78) begin
               // Broken history: too short, a stray byte, or no primary marker.
               clock_now = clock_now + step;
               case ($urandom_range(0, 2))
                  0: p.history_length = 4'($urandom_range(0, HISTORY_LEN - 1));
                  1: begin
                     lane = $urandom_range(0, HISTORY_LEN - 1);
                     p.history_bytes[8*lane +: 8] = 8'($urandom);
                  end
                  default: p.history_bytes = lost_history(1'b0);
               endcase
            end else if (kind < 84) begin
               // Time at or just before the window start.
               clock_now = window_start - 64'($urandom_range(0, 2));
            end else if (kind < 90) begin
               clock_now = clock_now + step;
               case ($urandom_range(0, 3))
                  0: link_poll.peer_address[$urandom_range(0, ADDR_W - 1)] ^= 1'b1;
                  1: link_poll.signal_level[$urandom_range(0, SIGNAL_W - 1)] ^= 1'b1;
                  2: link_poll.received_bytes[$urandom_range(0, BYTES_W - 1)] ^= 1'b1;
                  default: link_poll.screen_on = ~link_poll.screen_on;
               endcase
               p.peer_address = link_poll.peer_address;
               p.signal_level = link_poll.signal_level;
               p.received_bytes = link_poll.received_bytes;
               p.screen_on = link_poll.screen_on;
            end else if (kind < 94) begin
               clock_now = '0;
            end
            p.poll_time = clock_now[TIME_W-1:0];
            if (kind >= 94)
               p = random_poll();
            send_poll(p);
            left--;
         end
      end
   endtask

   // Reset settings: the basic window sequence, each way a poll fails, and link changes.
   task automatic test_directed_polls();
      poll_word_type p;
      logic [7:0]    pri;
      logic [7:0]    sec;
      pri = cfg_shadow.lost_marker_primary;
      sec = cfg_shadow.lost_marker_secondary;
      p.peer_address = '1;
      p.signal_level = -8'sd128;
      p.received_bytes = '1;
      p.screen_on = 1'b0;
      p.poll_time = '0;
      p.history_bytes = {HISTORY_LEN{pri}};
      p.history_length = HISTORY_LEN_MIN;
      // Nothing tracked yet, then a qualifying poll at time zero that leaves the window closed.
      send_poll(p);
      send_poll(p);
      // The window opens at 100, and a second poll at the same time restarts it.
      p.poll_time = 63'd100;
      send_poll(p);
      send_poll(p);
      // Screen off: three polls spanning exactly the window give a report.
      p.history_bytes = {pri, sec, 8'h00, sec, 8'h00, 8'h00, sec, 8'h00};
      p.poll_time = 63'd1500;
      send_poll(p);
      p.poll_time = 63'd3100;
      send_poll(p);
      p.poll_time = '0;
      send_poll(p);
      // Short histories, a stray byte, no primary marker, and all ones each close the window.
      p.poll_time = 63'd200;
      p.history_length = 4'd7;
      send_poll(p);
      p.history_length = 4'd0;
      send_poll(p);
      p.history_length = HISTORY_LEN_MIN;
      p.history_bytes = {{7{pri}}, 8'h05};
      send_poll(p);
      p.history_bytes = {{4{sec}}, {4{8'h00}}};
      send_poll(p);
      p.history_bytes = '1;
      send_poll(p);
      // Changing any one link field starts the tracking over.
      p.history_bytes = {pri, {7{8'h00}}};
      p.poll_time = 63'd300;
      p.signal_level = 8'sd127;
      send_poll(p);
      p.received_bytes = '0;
      send_poll(p);
      p.peer_address = '0;
      send_poll(p);
      p.screen_on = 1'b1;
      send_poll(p);
      // Screen on: five polls over the window, ending at the latest time, then a repeat.
      for (int k = 0; k <= 4; k++) begin
         p.poll_time = '1;
         p.poll_time = p.poll_time - TIME_W'(12000 - 3000 * k);
         send_poll(p);
      end
      p.poll_time = '1;
      send_poll(p);
      drain_results();
   endtask

   // Over 255 qualifying polls the count must hold at its maximum and still report.
   task automatic test_count_saturation();
      blld_cfg_type  c;
      poll_word_type p;
      c = cfg_shadow;
      c.min_polls_screen_on = COUNT_MAX;
      c.window_screen_on = 32'd1000000;
      write_config(c);
      p = random_poll();
      p.screen_on = 1'b1;
      p.history_length = HISTORY_LEN_MIN;
      p.poll_time = 63'd1;
      send_poll(p);
      for (int k = 0; k < 270; k++) begin
         p.history_bytes = lost_history(1'b1);
         p.poll_time = TIME_W'(k + 10);
         send_poll(p);
      end
      p.poll_time = 63'd2000000;
      send_poll(p);
      drain_results();
   endtask

   // Smallest and largest register values, including a zero minimum count.
   task automatic test_config_extremes();
      blld_cfg_type c;
      c.lost_marker_primary = 8'sd127;
      c.lost_marker_secondary = -8'sd128;
      c.window_screen_on = '0;
      c.window_screen_off = '0;
      c.min_polls_screen_on = '0;
      c.min_polls_screen_off = 8'd1;
      write_config(c);
      run_link_episodes(100);
      drain_results();
      c.lost_marker_primary = -8'sd128;
      c.lost_marker_secondary = 8'sd127;
      c.window_screen_on = '1;
      c.window_screen_off = '1;
      c.min_polls_screen_on = COUNT_MAX;
      c.min_polls_screen_off = COUNT_MAX;
      write_config(c);
      run_link_episodes(100);
      drain_results();
   endtask

   // Random register settings, each followed by a run of link episodes.
   task automatic test_random_settings();
      for (int phase = 0; phase < 6; phase++) begin
         write_config(pick_config());
         run_link_episodes(200);
         drain_results();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      cfg_shadow.lost_marker_primary = LOST_MARKER_PRIMARY_RST;
      cfg_shadow.lost_marker_secondary = LOST_MARKER_SECONDARY_RST;
      cfg_shadow.window_screen_on = WINDOW_SCREEN_ON_RST;
      cfg_shadow.window_screen_off = WINDOW_SCREEN_OFF_RST;
      cfg_shadow.min_polls_screen_on = MIN_POLLS_SCREEN_ON_RST;
      cfg_shadow.min_polls_screen_off = MIN_POLLS_SCREEN_OFF_RST;
      link_valid = 1'b0;
      link_address = '0;
      link_signal = '0;
      link_bytes = '0;
      link_screen = 1'b0;
      window_start = '0;
      polls_counted = '0;
      test_directed_polls();
      test_count_saturation();
      test_config_extremes();
      test_random_settings();
      drain_results();
      if (error_count == 0) begin
         $display("** beacon_loss_detector_core: PASSED **");
      end else begin
         $display("** beacon_loss_detector_core: FAILED **");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #20_000_000;
      $display("** beacon_loss_detector_core: FAILED **");
      $finish;
   end

endmodule
